FILE: sv/pnd_pkg.sv
// ----------------------------------------------------------------------------
// pnd_pkg: shared types and constants for the PCM normalizer / downmixer
// Format codes, register indexes and fixed-point limits.
// ----------------------------------------------------------------------------
package pnd_pkg;

  localparam logic [2:0] FMT_U8  = 3'd0;
  localparam logic [2:0] FMT_S16 = 3'd1;
  localparam logic [2:0] FMT_S24 = 3'd2;
  localparam logic [2:0] FMT_S32 = 3'd3;
  localparam logic [2:0] FMT_F32 = 3'd4;
  localparam logic [2:0] FMT_F64 = 3'd5;

  localparam logic [1:0] REG_FORMAT   = 2'd0;
  localparam logic [1:0] REG_CHANNELS = 2'd1;
  localparam logic [1:0] REG_LEFT     = 2'd2;

  localparam logic [24:0] Q23_ONE    = 25'h0800000;
  localparam logic [23:0] FULL_SCALE = 24'd8387769;

  typedef struct packed {
    logic signed [24:0] value;
    logic               clamped;
  } dec_t;

endpackage

FILE: sv/pnd_decode.sv
// ----------------------------------------------------------------------------
// pnd_decode: raw sample to signed Q23
// Combinational decode of PCM and float formats with clamp and NaN handling.
// ----------------------------------------------------------------------------
module pnd_decode import pnd_pkg::*; (
  input  logic [2:0]  fmt_i,
  input  logic [63:0] bits_i,
  output dec_t        dec_o
);

  logic [7:0]  e32;
  logic [10:0] e64;
  logic [22:0] m32;
  logic [51:0] m64;
  logic [10:0] sh64;
  logic [7:0]  sh32;
  logic [52:0] full64;
  logic [23:0] mag;
  logic        neg;

  assign e32  = bits_i[30:23];
  assign m32  = bits_i[22:0];
  assign e64  = bits_i[62:52];
  assign m64  = bits_i[51:0];
  assign sh32 = 8'd127 - e32;
  assign sh64 = 11'd1052 - e64;
  assign full64 = {1'b1, m64} >> sh64[5:0];

  always_comb begin
    dec_o = '0;
    mag = '0;
    neg = 1'b0;
    case (fmt_i)
      // offset binary: flipping the top bit gives x - 128, sign-extended
      FMT_U8:  dec_o.value = {~bits_i[7], ~bits_i[7], bits_i[6:0], 16'h0};
      FMT_S16: dec_o.value = {{1{bits_i[15]}}, bits_i[15:0], 8'h0};
      FMT_S24: dec_o.value = {bits_i[23], bits_i[23:0]};
      FMT_S32: dec_o.value = {bits_i[31], bits_i[31:8]};
      FMT_F32: begin
        neg = bits_i[31];
        if (e32 == 8'hFF && m32 != '0) mag = '0;
        else if (e32 > 8'd127 || (e32 == 8'd127 && m32 != '0)) begin
          dec_o.clamped = 1'b1;
          dec_o.value = neg ? -$signed(Q23_ONE) : $signed(Q23_ONE);
        end else if (e32 != '0 && sh32 < 8'd24) mag = {1'b1, m32} >> sh32[4:0];
        if (!dec_o.clamped) dec_o.value = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
      FMT_F64: begin
        neg = bits_i[63];
        if (e64 == 11'h7FF && m64 != '0) mag = '0;
        else if (e64 > 11'd1023 || (e64 == 11'd1023 && m64 != '0)) begin
          dec_o.clamped = 1'b1;
          dec_o.value = neg ? -$signed(Q23_ONE) : $signed(Q23_ONE);
        end else if (e64 != '0 && sh64 < 11'd53) mag = full64[23:0];
        if (!dec_o.clamped) dec_o.value = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
      default: dec_o = '0;
    endcase
  end

endmodule

FILE: sv/pcm_normalize_downmix.sv
// ----------------------------------------------------------------------------
// pcm_normalize_downmix: sample normalizer and mono downmixer
// Decodes one sample per request; per frame, unless left-only, divides the
// channel sum by the channel count (shift/subtract) and tracks stereo energy.
// ----------------------------------------------------------------------------
// channel | direction | handshake
// cfg     | in        | cfg_we_i, cfg_idx_i, cfg_data_i
// sample  | in        | sample_valid_i / sample_stall_o
// mono    | out       | mono_valid_o / mono_stall_i
// Non-final sample: accept, then decode. Frame-ending sample: accept, decode,
// finish and output in left-only mode; a channel mean adds a 28-step restoring
// divider, and stereo mean mode also a shared 25x25 multiplier that adds LL,
// RR and LR one per cycle. Reset sets control registers to defaults and
// clears all file state. The result waits in an output register while
// stalled; no request is taken until it leaves.
module pcm_normalize_downmix import pnd_pkg::*; #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_FRAMES   = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        sample_valid_i,
  output logic        sample_stall_o,
  input  logic [63:0] sample_bits_i,
  input  logic        last_sample_i,
  output logic        mono_valid_o,
  input  logic        mono_stall_i,
  output logic signed [24:0] mono_sample_o,
  output logic        end_of_file_o,
  output logic        phase_cancel_o,
  output logic        already_clipped_o,
  output logic [19:0] clamped_count_o,
  output logic [16:0] full_scale_count_o
);

  localparam int CW = $clog2(MAX_CHANNELS + 1);
  localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [19:0] CLAMP_LIM = 20'(MAX_FRAMES * MAX_CHANNELS);
  localparam logic [16:0] FRAME_LIM = 17'(MAX_FRAMES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [2:0] fmt_q;
  logic [3:0] chn_q;
  logic       left_q;
  logic [63:0] bits_q;
  logic        last_q;
  dec_t        dec;

  logic [IW-1:0] idx_q;
  logic signed [27:0] sum_q;
  logic signed [24:0] left_val_q, right_q;
  logic [16:0] frames_q, fs_q;
  logic [19:0] clamp_q;
  logic [63:0] ll_q, rr_q;
  logic signed [63:0] lr_q;
  logic [27:0] quo_q, rem_q;
  logic [4:0]  step_q;
  logic [1:0]  mstep_q;
  logic        neg_q;
  logic signed [24:0] mono_q;

  logic [CW-1:0] ch_eff;
  logic [28:0]   rem_sh;
  logic signed [24:0] ma, mb;
  logic signed [49:0] prod;
  logic signed [64:0] lr_sum;
  logic [64:0]   u_sum;
  logic [24:0]   mono_mag;

  pnd_decode u_dec (.fmt_i(fmt_q), .bits_i(bits_q), .dec_o(dec));

  always_comb begin
    if (chn_q == '0) ch_eff = CW'(1);
    else if (32'(chn_q) > MAX_CHANNELS) ch_eff = CW'(MAX_CHANNELS);
    else ch_eff = CW'(chn_q);
  end

  assign rem_sh  = {rem_q, quo_q[27]};
  assign ma = (mstep_q == 2'd1) ? right_q : left_val_q;
  assign mb = (mstep_q == 2'd0) ? left_val_q : right_q;
  assign prod = ma * mb;
  assign u_sum = {1'b0, (mstep_q == 2'd0) ? ll_q : rr_q} + {16'd0, prod[48:0]};
  assign lr_sum = {lr_q[63], lr_q} + 65'(prod);
  assign mono_mag = mono_q[24] ? 25'(-mono_q) : 25'(mono_q);

  assign sample_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (sample_valid_i) state_d = S_DEC;
      S_DEC: begin
        if (32'(idx_q) + 1 < 32'(ch_eff)) state_d = S_IDLE;
        else if (left_q) state_d = S_FIN;
        else state_d = S_DIV;
      end
      S_DIV: if (step_q == 5'd27) state_d = (ch_eff == CW'(2)) ? S_MUL : S_FIN;
      S_MUL: if (mstep_q == 2'd2) state_d = S_FIN;
      S_FIN: state_d = S_OUT;
      S_OUT: if (!mono_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fmt_q <= FMT_S16; chn_q <= 4'd1; left_q <= 1'b0;
      bits_q <= '0; last_q <= 1'b0; right_q <= '0;
      idx_q <= '0; sum_q <= '0; left_val_q <= '0;
      frames_q <= '0; fs_q <= '0; clamp_q <= '0;
      ll_q <= '0; rr_q <= '0; lr_q <= '0;
      quo_q <= '0; rem_q <= '0; neg_q <= 1'b0; mono_q <= '0;
      step_q <= '0; mstep_q <= '0;
      mono_sample_o <= '0; clamped_count_o <= '0; full_scale_count_o <= '0;
      end_of_file_o <= 1'b0; phase_cancel_o <= 1'b0; already_clipped_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_FORMAT:   fmt_q <= cfg_data_i[2:0];
          REG_CHANNELS: chn_q <= cfg_data_i;
          REG_LEFT:     left_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: if (sample_valid_i) begin
          bits_q <= sample_bits_i;
          last_q <= last_sample_i;
        end
        S_DEC: begin
          logic signed [27:0] ns;
          ns = (idx_q == '0) ? 28'(dec.value) : sum_q + 28'(dec.value);
          right_q <= dec.value;
          step_q <= '0; mstep_q <= '0;
          if (32'(idx_q) + 1 < 32'(ch_eff)) begin
            if (last_q) begin
              // partial last frame: drop it and the file's totals
              idx_q <= '0; sum_q <= '0; left_val_q <= '0;
              frames_q <= '0; fs_q <= '0; clamp_q <= '0;
              ll_q <= '0; rr_q <= '0; lr_q <= '0;
            end else begin
              idx_q <= idx_q + IW'(1);
              sum_q <= ns;
              if (idx_q == '0) left_val_q <= dec.value;
              if (dec.clamped && clamp_q < CLAMP_LIM) clamp_q <= clamp_q + 20'd1;
            end
          end else begin
            idx_q <= '0;
            sum_q <= ns;
            if (idx_q == '0) left_val_q <= dec.value;
            if (dec.clamped && clamp_q < CLAMP_LIM) clamp_q <= clamp_q + 20'd1;
            neg_q <= ns[27];
            quo_q <= ns[27] ? 28'(-ns) : 28'(ns);
            rem_q <= '0;
            mono_q <= (idx_q == '0) ? dec.value : left_val_q;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (rem_sh >= 29'(ch_eff)) begin
            rem_q <= 28'(rem_sh - 29'(ch_eff));
            quo_q <= {quo_q[26:0], 1'b1};
          end else begin
            rem_q <= rem_sh[27:0];
            quo_q <= {quo_q[26:0], 1'b0};
          end
          step_q <= step_q + 5'd1;
          if (step_q == 5'd27)
            mono_q <= neg_q ? -$signed(25'({quo_q[26:0], rem_sh >= 29'(ch_eff)}))
                            : $signed(25'({quo_q[26:0], rem_sh >= 29'(ch_eff)}));
        end
        S_MUL: begin
          mstep_q <= mstep_q + 2'd1;
          if (mstep_q == 2'd0) ll_q <= u_sum[64] ? '1 : u_sum[63:0];
          else if (mstep_q == 2'd1) rr_q <= u_sum[64] ? '1 : u_sum[63:0];
          else if (lr_sum[64] != lr_sum[63])
            lr_q <= lr_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          else lr_q <= lr_sum[63:0];
        end
        S_FIN: begin
          logic [16:0] nf, nfs;
          nf  = (frames_q < FRAME_LIM) ? frames_q + 17'd1 : frames_q;
          nfs = (mono_mag >= 25'(FULL_SCALE) && fs_q < FRAME_LIM) ? fs_q + 17'd1 : fs_q;
          mono_sample_o <= mono_q;
          end_of_file_o <= last_q;
          clamped_count_o <= clamp_q;
          full_scale_count_o <= nfs;
          phase_cancel_o <= last_q && ll_q != '0 && rr_q != '0 && lr_q[63];
          already_clipped_o <= last_q && (27'(nfs) * 27'd1000 > 27'(nf));
          if (last_q) begin
            frames_q <= '0; fs_q <= '0; clamp_q <= '0; sum_q <= '0;
            left_val_q <= '0; ll_q <= '0; rr_q <= '0; lr_q <= '0;
          end else begin
            frames_q <= nf; fs_q <= nfs;
          end
        end
        default: ;
      endcase
    end
  end

  assign mono_valid_o = (state_q == S_OUT);

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> sample_stall_o) else $error("accept while busy");
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(mono_valid_o) |-> $past(state_q) == S_FIN) else $error("bad out entry");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> step_q <= 5'd27) else $error("divider overrun");
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fs_q <= frames_q) else $error("full scale above frames");

endmodule
